// ===== rtl/core/epwt_pkg.sv =====
// Shared types, constants and the cosine table for the pressure-volume work tracker.
`default_nettype none
package epwt_pkg;

    localparam int COS_TABLE_BITS = 10;
    localparam int COS_Q_LEN      = (1 << (COS_TABLE_BITS - 2)) + 1;
    localparam int COS_IDX_W      = COS_TABLE_BITS - 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SKIP_COUNT   = 3'd0,
        REG_HOT_AREA     = 3'd1,
        REG_HOT_RADIUS   = 3'd2,
        REG_HOT_VMIN     = 3'd3,
        REG_COLD_AREA    = 3'd4,
        REG_COLD_RADIUS  = 3'd5,
        REG_COLD_VMIN    = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_VOL,
        ST_WORK,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic vol;
        logic work;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
    } dp_status_t;

    typedef logic [15:0] cos_lut_t [COS_Q_LEN];

    // Quarter-wave cosine magnitudes in Q15, built at elaboration
    function automatic cos_lut_t cos_build();
        cos_lut_t        lut;
        longint unsigned p;
        longint unsigned th;
        longint unsigned t;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned d;
        longint unsigned h;
        longint unsigned e;
        for (int j = 0; j < COS_Q_LEN; j++)
        begin
            p  = longint'(j) << (16 - COS_TABLE_BITS);
            th = (p * 64'd1686629713) >> 14;
            t  = (th * th) >> 30;
            a  = (64'd1 << 30) - t / 90;
            b  = (64'd1 << 30) - ((t * a) >> 30) / 56;
            c  = (64'd1 << 30) - ((t * b) >> 30) / 30;
            d  = (64'd1 << 30) - ((t * c) >> 30) / 12;
            h  = ((t * d) >> 30) >> 1;
            e  = (h >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - h;
            lut[j] = 16'((e + 64'd16384) >> 15);
        end
        return lut;
    endfunction

    localparam cos_lut_t COS_LUT = cos_build();

endpackage
`default_nettype wire

// ===== rtl/core/epwt_ctrl.sv =====
// Sequencing state machine for the pressure-volume work tracker.
`default_nettype none
module epwt_ctrl
    import epwt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // Hold state and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance through the compute steps
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.skip)
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_VOL;
            end
            ST_VOL:
            begin
                cmd.vol    = 1'b1;
                state_next = ST_WORK;
            end
            ST_WORK:
            begin
                cmd.work   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/epwt_datapath.sv =====
// Registers, cycle tracking, volume and work arithmetic of the tracker.
`default_nettype none
module epwt_datapath
    import epwt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic signed [31:0]     angle,
    input  wire logic [19:0]            pressure,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    output logic [31:0]                 cycle_number,
    output logic [15:0]                 stage_index,
    output logic signed [31:0]          phase,
    output logic [26:0]                 volume,
    output logic signed [47:0]          work
);

    localparam logic signed [33:0] TURN34 = 34'sd65536;
    localparam logic [28:0] VOL_MAX = 29'(27'h7FFFFFF);

    // configuration
    logic [9:0]  skip_count_reg;
    logic [15:0] hot_area_reg, hot_radius_reg, cold_area_reg, cold_radius_reg;
    logic [23:0] hot_vmin_reg, cold_vmin_reg;

    // tracking state
    logic [9:0]         skipped_reg;
    logic               started_reg;
    logic signed [33:0] start_reg;
    logic [31:0]        cycle_reg;
    logic [15:0]        stage_reg;
    logic [19:0]        last_pres_reg;
    logic [26:0]        last_vol_reg;

    // per-sample working registers
    logic               first_reg;
    logic [15:0]        frac_reg;
    logic [19:0]        pres_reg;
    logic signed [31:0] phase_reg;
    logic [31:0]        hot_ar_reg, cold_ar_reg;
    logic [16:0]        factor_reg;
    logic [48:0]        hot_prod_reg, cold_prod_reg;
    logic [26:0]        vol_reg;
    logic signed [47:0] work_reg;

    // output payload
    logic [31:0]        cyc_out_reg;
    logic [15:0]        stage_out_reg;
    logic signed [31:0] phase_out_reg;
    logic [26:0]        vol_out_reg;
    logic signed [47:0] work_out_reg;

    logic               skip;
    logic signed [33:0] ang34, start_eff, start_new, ph34;
    logic               new_cycle;
    logic [31:0]        cycle_new;
    logic [15:0]        stage_new;
    logic signed [31:0] phase_sat;

    logic [COS_TABLE_BITS:0] k_full, k_half;
    logic                    cos_neg;
    logic [15:0]             cos_mag;

    logic [49:0] hot_rnd, cold_rnd;
    logic [27:0] hot_vol, cold_vol;
    logic [28:0] vol_sum;

    logic [20:0]        pres_sum;
    logic signed [27:0] vol_diff;
    logic signed [49:0] work_prod;

    // Decide skip and the cycle update for the offered sample
    always_comb
    begin
        skip      = !started_reg && (skipped_reg < skip_count_reg);
        ang34     = 34'(angle);
        start_eff = started_reg ? start_reg : {ang34[33:16], 16'h0000};
        new_cycle = (ang34 >= start_eff + TURN34);
        start_new = new_cycle ? start_eff + TURN34 : start_eff;
        if (new_cycle)
        begin
            cycle_new = (cycle_reg != 32'hFFFFFFFF) ? cycle_reg + 32'd1 : cycle_reg;
            stage_new = 16'd1;
        end
        else
        begin
            cycle_new = cycle_reg;
            stage_new = (stage_reg != 16'hFFFF) ? stage_reg + 16'd1 : stage_reg;
        end
        ph34 = ang34 - start_new;
        if (ph34 > 34'sd2147483647)
        begin
            phase_sat = 32'sh7FFFFFFF;
        end
        else if (ph34 < -34'sd2147483648)
        begin
            phase_sat = 32'sh80000000;
        end
        else
        begin
            phase_sat = ph34[31:0];
        end
    end

    assign status.skip = skip;

    // Fold the angle fraction onto the quarter-wave table
    always_comb
    begin
        k_full = {1'b0, frac_reg[15 -: COS_TABLE_BITS]};
        if (k_full > (COS_TABLE_BITS+1)'(1 << (COS_TABLE_BITS - 1)))
        begin
            k_full = (COS_TABLE_BITS+1)'(1 << COS_TABLE_BITS) - k_full;
        end
        cos_neg = 1'b0;
        k_half  = k_full;
        if (k_full > (COS_TABLE_BITS+1)'(1 << (COS_TABLE_BITS - 2)))
        begin
            k_half  = (COS_TABLE_BITS+1)'(1 << (COS_TABLE_BITS - 1)) - k_full;
            cos_neg = 1'b1;
        end
        cos_mag = COS_LUT[k_half[COS_IDX_W-1:0]];
    end

    // Round, offset and sum the cylinder volumes
    always_comb
    begin
        hot_rnd  = 50'(hot_prod_reg) + 50'd4194304;
        cold_rnd = 50'(cold_prod_reg) + 50'd4194304;
        hot_vol  = 28'(hot_rnd[49:23]) + 28'(hot_vmin_reg);
        cold_vol = 28'(cold_rnd[49:23]) + 28'(cold_vmin_reg);
        vol_sum  = 29'(hot_vol) + 29'(cold_vol);
    end

    // Pressure sum times volume change; halved in the work step
    always_comb
    begin
        pres_sum  = 21'(pres_reg) + 21'(last_pres_reg);
        vol_diff  = signed'({1'b0, vol_reg}) - signed'({1'b0, last_vol_reg});
        work_prod = 50'(signed'({1'b0, pres_sum})) * 50'(vol_diff);
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg  <= 10'd100;
            hot_area_reg    <= '0;
            hot_radius_reg  <= '0;
            hot_vmin_reg    <= '0;
            cold_area_reg   <= '0;
            cold_radius_reg <= '0;
            cold_vmin_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SKIP_COUNT:  skip_count_reg  <= cfg_data[9:0];
                REG_HOT_AREA:    hot_area_reg    <= cfg_data[15:0];
                REG_HOT_RADIUS:  hot_radius_reg  <= cfg_data[15:0];
                REG_HOT_VMIN:    hot_vmin_reg    <= cfg_data;
                REG_COLD_AREA:   cold_area_reg   <= cfg_data[15:0];
                REG_COLD_RADIUS: cold_radius_reg <= cfg_data[15:0];
                REG_COLD_VMIN:   cold_vmin_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Update tracking state on each transaction and after the work step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skipped_reg   <= '0;
            started_reg   <= 1'b0;
            start_reg     <= '0;
            cycle_reg     <= 32'd1;
            stage_reg     <= 16'd1;
            last_pres_reg <= '0;
            last_vol_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (skip)
                begin
                    skipped_reg <= skipped_reg + 10'd1;
                end
                else
                begin
                    started_reg <= 1'b1;
                    start_reg   <= start_new;
                    cycle_reg   <= cycle_new;
                    stage_reg   <= stage_new;
                end
            end
            if (cmd.work)
            begin
                last_pres_reg <= pres_reg;
                last_vol_reg  <= vol_reg;
            end
        end
    end

    // Run the arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            first_reg <= !started_reg;
            frac_reg  <= angle[15:0];
            pres_reg  <= pressure;
            phase_reg <= phase_sat;
        end
        if (cmd.mul1)
        begin
            hot_ar_reg  <= 32'(hot_area_reg) * 32'(hot_radius_reg);
            cold_ar_reg <= 32'(cold_area_reg) * 32'(cold_radius_reg);
            factor_reg  <= cos_neg ? 17'd32768 - 17'(cos_mag) : 17'd32768 + 17'(cos_mag);
        end
        if (cmd.mul2)
        begin
            hot_prod_reg  <= 49'(hot_ar_reg) * 49'(factor_reg);
            cold_prod_reg <= 49'(cold_ar_reg) * 49'(factor_reg);
        end
        if (cmd.vol)
        begin
            vol_reg <= (vol_sum > VOL_MAX) ? 27'h7FFFFFF : vol_sum[26:0];
        end
        if (cmd.work)
        begin
            work_reg <= first_reg ? 48'sd0 : 48'(work_prod >>> 1);
        end
        if (cmd.load_out)
        begin
            cyc_out_reg   <= cycle_reg;
            stage_out_reg <= stage_reg;
            phase_out_reg <= phase_reg;
            vol_out_reg   <= vol_reg;
            work_out_reg  <= work_reg;
        end
    end

    assign cycle_number = cyc_out_reg;
    assign stage_index  = stage_out_reg;
    assign phase        = phase_out_reg;
    assign volume       = vol_out_reg;
    assign work         = work_out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/engine_pv_work_tracker.sv =====
// After its transaction a kept sample passes the MUL1, MUL2, VOL and WORK states
// and is loaded into the output register in ST_OUT; no new sample is taken until
// then. A skipped sample is taken in ST_IDLE and the controller stays there.
// The output register lets the next sample enter while a result waits.
// Reset (rst_n, asynchronous, active low) restores configuration and tracking registers.
`default_nettype none
module engine_pv_work_tracker
    import epwt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [31:0]     angle,
    input  wire logic [19:0]            pressure,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [31:0]                 cycle_number,
    output logic [15:0]                 stage_index,
    output logic signed [31:0]          phase,
    output logic [26:0]                 volume,
    output logic signed [47:0]          work
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the steps
    epwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Compute the results
    epwt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .angle        (angle),
        .pressure     (pressure),
        .cmd          (cmd),
        .status       (status),
        .cycle_number (cycle_number),
        .stage_index  (stage_index),
        .phase        (phase),
        .volume       (volume),
        .work         (work)
    );

endmodule
`default_nettype wire

// ===== tb/tb_engine_pv_work_tracker.sv =====
// Self-checking testbench for the pressure-volume work tracker.
`default_nettype none
module tb_engine_pv_work_tracker
    import epwt_pkg::*;
();

    typedef struct {
        logic signed [31:0] angle;
        logic [19:0]        pressure;
    } sample_t;

    typedef struct {
        logic [31:0]        cycle_number;
        logic [15:0]        stage_index;
        logic signed [31:0] phase;
        logic [26:0]        volume;
        logic signed [47:0] work;
    } pv_point_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [31:0]     angle;
    logic [19:0]            pressure;
    logic                   out_valid;
    logic                   out_stall;
    logic [31:0]            cycle_number;
    logic [15:0]            stage_index;
    logic signed [31:0]     phase;
    logic [26:0]            volume;
    logic signed [47:0]     work;

    engine_pv_work_tracker dut (.*);

    // Predictor configuration and state
    int unsigned     skip_limit;
    longint unsigned hot_area, hot_radius, hot_vmin;
    longint unsigned cold_area, cold_radius, cold_vmin;
    int unsigned     skip_seen;
    bit              running;
    longint          turn_start;
    longint unsigned cycle_cnt, stage_cnt, prev_pressure, prev_volume;

    sample_t   pending_samples[$];
    pv_point_t expected_points[$];
    int        error_count;
    int        hold_off;

    // Cosine of a table index in Q15 via quadrant folding and a Q30 series
    function automatic int cos_q15(int unsigned k);
        longint unsigned p, th, t, a, b, c, d, h, e;
        bit neg;
        int r;
        neg = 0;
        p = longint'(k & ((1 << COS_TABLE_BITS) - 1)) << (16 - COS_TABLE_BITS);
        if (p > 32768) p = 65536 - p;
        if (p > 16384)
        begin
            p = 32768 - p;
            neg = 1;
        end
        th = (p * 64'd1686629713) >> 14;
        t  = (th * th) >> 30;
        a  = (64'd1 << 30) - t / 90;
        b  = (64'd1 << 30) - ((t * a) >> 30) / 56;
        c  = (64'd1 << 30) - ((t * b) >> 30) / 30;
        d  = (64'd1 << 30) - ((t * c) >> 30) / 12;
        h  = ((t * d) >> 30) >> 1;
        e  = (h >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - h;
        r  = int'((e + 64'd16384) >> 15);
        return neg ? -r : r;
    endfunction

    function automatic longint unsigned cyl_vol(longint unsigned ar, longint unsigned rad,
                                                 longint unsigned vmin, int cs);
        longint unsigned f;
        f = longint'(32768 + cs);
        return ((ar * rad * f + (64'd1 << 22)) >> 23) + vmin;
    endfunction

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SKIP_COUNT:  skip_limit  = val & 32'h3FF;
            REG_HOT_AREA:    hot_area    = val & 32'hFFFF;
            REG_HOT_RADIUS:  hot_radius  = val & 32'hFFFF;
            REG_HOT_VMIN:    hot_vmin    = val & 32'hFFFFFF;
            REG_COLD_AREA:   cold_area   = val & 32'hFFFF;
            REG_COLD_RADIUS: cold_radius = val & 32'hFFFF;
            REG_COLD_VMIN:   cold_vmin   = val & 32'hFFFFFF;
            default: ;
        endcase
    endtask

    // Advance the predictor by one accepted sample
    task automatic track_sample(sample_t s);
        longint          ang, ph, prod, wk;
        longint unsigned raw, vol;
        bit              first;
        int              cs;
        pv_point_t       pt;
        raw = longint'(s.angle) & 64'hFFFFFFFF;
        ang = longint'(s.angle);
        first = 0;
        if (!running)
        begin
            if (skip_seen < skip_limit)
            begin
                skip_seen++;
                return;
            end
            running = 1;
            first = 1;
            turn_start = ang - longint'(raw & 64'hFFFF);
        end
        if (ang >= turn_start + 65536)
        begin
            if (cycle_cnt != 64'hFFFFFFFF) cycle_cnt++;
            stage_cnt = 1;
            turn_start += 65536;
        end
        else if (stage_cnt < 16'hFFFF)
            stage_cnt++;
        ph = ang - turn_start;
        if (ph > 64'sd2147483647) ph = 64'sd2147483647;
        if (ph < -64'sd2147483648) ph = -64'sd2147483648;
        cs  = cos_q15(int'((raw & 64'hFFFF) >> (16 - COS_TABLE_BITS)));
        vol = cyl_vol(hot_area, hot_radius, hot_vmin, cs)
            + cyl_vol(cold_area, cold_radius, cold_vmin, cs);
        if (vol > 134217727) vol = 134217727;
        wk = 0;
        if (!first)
        begin
            prod = longint'(s.pressure + prev_pressure) * (longint'(vol) - longint'(prev_volume));
            wk = (prod >= 0) ? (prod >>> 1) : -((-prod + 1) >>> 1);
            if (wk > 64'sd140737488355327) wk = 64'sd140737488355327;
            if (wk < -64'sd140737488355328) wk = -64'sd140737488355328;
        end
        prev_pressure = s.pressure;
        prev_volume   = vol;
        pt.cycle_number = cycle_cnt[31:0];
        pt.stage_index  = stage_cnt[15:0];
        pt.phase        = ph[31:0];
        pt.volume       = vol[26:0];
        pt.work         = wk[47:0];
        expected_points.insert(expected_points.size(), pt);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: offer queued samples with random gaps
    int send_gap;
    initial send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            angle    <= '0;
            pressure <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_sample(pending_samples.pop_front());
            end
            if (in_valid && in_stall)
                ; // hold payload
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_samples.size() > (in_valid ? 1 : 0) - (in_valid ? 1 : 0)
                     && pending_samples.size() > 0 && !(in_valid && !in_stall
                     && pending_samples.size() == 0))
            begin
                in_valid <= 1'b1;
                angle    <= pending_samples[0].angle;
                pressure <= pending_samples[0].pressure;
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: random stalls, long hold-off on request, compare results
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        pv_point_t exp_pt;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result cycle=%0d", $time, cycle_number);
                    error_count++;
                end
                else
                begin
                    exp_pt = expected_points.pop_front();
                    if (exp_pt.cycle_number !== cycle_number)
                    begin
                        $display("%0t: cycle_number exp %0d got %0d", $time,
                                 exp_pt.cycle_number, cycle_number);
                        error_count++;
                    end
                    if (exp_pt.stage_index !== stage_index)
                    begin
                        $display("%0t: stage_index exp %0d got %0d", $time,
                                 exp_pt.stage_index, stage_index);
                        error_count++;
                    end
                    if (exp_pt.phase !== phase)
                    begin
                        $display("%0t: phase exp %0d got %0d", $time, exp_pt.phase, phase);
                        error_count++;
                    end
                    if (exp_pt.volume !== volume)
                    begin
                        $display("%0t: volume exp %0d got %0d", $time, exp_pt.volume, volume);
                        error_count++;
                    end
                    if (exp_pt.work !== work)
                    begin
                        $display("%0t: work exp %0d got %0d", $time, exp_pt.work, work);
                        error_count++;
                    end
                end
                recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 0;
                out_stall <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off  <= hold_off - 1;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_sample(logic signed [31:0] a, logic [19:0] p);
        sample_t s;
        s.angle = a;
        s.pressure = p;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_random_volumes();
        write_reg(REG_HOT_AREA,    $urandom_range(0, 65535));
        write_reg(REG_HOT_RADIUS,  $urandom_range(0, 65535));
        write_reg(REG_HOT_VMIN,    $urandom_range(0, 16777215));
        write_reg(REG_COLD_AREA,   $urandom_range(0, 65535));
        write_reg(REG_COLD_RADIUS, $urandom_range(0, 65535));
        write_reg(REG_COLD_VMIN,   $urandom_range(0, 16777215));
    endtask

    // Stimulus
    initial
    begin
        logic signed [31:0] a;
        error_count = 0;
        hold_off = 0;
        skip_limit = 100;
        hot_area = 0; hot_radius = 0; hot_vmin = 0;
        cold_area = 0; cold_radius = 0; cold_vmin = 0;
        skip_seen = 0; running = 0; turn_start = 0;
        cycle_cnt = 1; stage_cnt = 1; prev_pressure = 0; prev_volume = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; angle = '0; pressure = '0; out_stall = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Skip a few under the reset count, then lower it to end skipping
        for (int i = 0; i < 3; i++) queue_sample($urandom, 20'($urandom));
        drain();
        write_reg(REG_SKIP_COUNT, 2);
        write_reg(REG_HOT_AREA, 65535);
        write_reg(REG_HOT_RADIUS, 65535);
        write_reg(REG_HOT_VMIN, 16777215);
        write_reg(REG_COLD_AREA, 65535);
        write_reg(REG_COLD_RADIUS, 65535);
        write_reg(REG_COLD_VMIN, 16777215);

        // Directed: extremes, backward angle, big jump, wraparound
        queue_sample(32'sh7FFF_FFFF, 20'hFFFFF);
        queue_sample(32'sh8000_0000, 20'h00000);
        queue_sample(32'sh8000_0000, 20'hFFFFF);
        queue_sample(32'sh7FFF_0000, 20'hFFFFF);
        queue_sample(32'sh0000_0000, 20'h12345);
        queue_sample(32'sh0001_0000, 20'h00001);
        queue_sample(32'sh0000_8000, 20'hFFFFF);
        queue_sample(32'sh0004_4000, 20'h80000);
        queue_sample(32'shFFFF_C000, 20'h00000);
        drain();

        write_reg(REG_HOT_AREA, 0);
        write_reg(REG_COLD_AREA, 0);
        write_reg(REG_HOT_VMIN, 0);
        write_reg(REG_COLD_VMIN, 0);
        queue_sample(32'sh0000_0100, 20'h00001);
        queue_sample(32'sh0000_0200, 20'h00002);
        drain();

        // Long receiver hold-off while samples keep coming
        set_random_volumes();
        hold_off = 300;
        a = $urandom;
        for (int i = 0; i < 40; i++)
        begin
            a = a + $urandom_range(0, 8000);
            queue_sample(a, 20'($urandom));
        end
        drain();

        // Random phases: mostly steady rotation, some jumps and reversals
        for (int ph_i = 0; ph_i < 7; ph_i++)
        begin
            set_random_volumes();
            if (ph_i == 3)
            begin
                write_reg(REG_HOT_AREA, 65535);
                write_reg(REG_HOT_RADIUS, 65535);
                write_reg(REG_COLD_AREA, 65535);
                write_reg(REG_COLD_RADIUS, 65535);
            end
            a = $urandom;
            for (int i = 0; i < 95; i++)
            begin
                case ($urandom_range(0, 9))
                    0: a = $urandom;
                    1: a = a - $urandom_range(0, 20000);
                    2: a = a + $urandom_range(65536, 300000);
                    default: a = a + $urandom_range(0, 12000);
                endcase
                queue_sample(a, 20'($urandom));
            end
            drain();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Global timeout
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
